>>> rtl/vau_pkg.sv
// Shared types, opcodes and saturation helper for the vector arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package vau_pkg;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned SQRT_STAGES = 32;
   localparam int unsigned SAT_W       = 68;

   localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

   typedef logic [3:0] opcode_type;

   localparam opcode_type OP_ADDV  = 4'd0;
   localparam opcode_type OP_ADDS  = 4'd1;
   localparam opcode_type OP_SUBV  = 4'd2;
   localparam opcode_type OP_SUBS  = 4'd3;
   localparam opcode_type OP_MULV  = 4'd4;
   localparam opcode_type OP_MULS  = 4'd5;
   localparam opcode_type OP_DIVV  = 4'd6;
   localparam opcode_type OP_DIVS  = 4'd7;
   localparam opcode_type OP_DOT   = 4'd8;
   localparam opcode_type OP_CROSS = 4'd9;
   localparam opcode_type OP_MAGSQ = 4'd10;
   localparam opcode_type OP_MAG   = 4'd11;
   localparam opcode_type OP_NORM  = 4'd12;

   // per-component state handed from a lane to the back end
   typedef struct packed {
      logic signed [WORD_W-1:0] res;      // add/sub/mul/cross result
      logic                     ov;
      logic [WORD_W-1:0]        num;      // |a|
      logic [WORD_W-1:0]        den;      // |b| or |s|
      logic                     neg;      // quotient sign
      logic                     num_neg;  // a < 0
      logic                     den_zero; // raw divisor is zero
   } lane_side_type;

   typedef struct packed {
      opcode_type               op;
      lane_side_type [2:0]      lanes;
      logic signed [WORD_W-1:0] rs;
      logic                     rs_ov;
      logic                     sq_zero;
   } side_type;

   // returns {overflow, clamped 32-bit value}
   function automatic logic [WORD_W:0] sat_word(input logic signed [SAT_W-1:0] v);
      logic hi_same;
      hi_same = (v[SAT_W-1:WORD_W-1] == '0) || (v[SAT_W-1:WORD_W-1] == '1);
      if (hi_same) begin
         return {1'b0, v[WORD_W-1:0]};
      end else if (v[SAT_W-1]) begin
         return {1'b1, WORD_MIN};
      end else begin
         return {1'b1, WORD_MAX};
      end
   endfunction

endpackage
`default_nettype wire

>>> rtl/vau_lane.sv
// One component lane: operand select, two multipliers, add/sub, mul and cross results.
`timescale 1ns / 1ps
`default_nettype none
module vau_lane #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   en,
   input  vau_pkg::opcode_type    op_in,
   input  vau_pkg::opcode_type    op_s1,
   input  logic signed [31:0]     a_own,
   input  logic signed [31:0]     b_own,
   input  logic signed [31:0]     s,
   input  logic signed [31:0]     cx_a0,
   input  logic signed [31:0]     cx_b0,
   input  logic signed [31:0]     cx_a1,
   input  logic signed [31:0]     cx_b1,
   output logic signed [63:0]     prod,
   output vau_pkg::lane_side_type lane_o
);
   import vau_pkg::*;

   logic                     is_cross, is_sq, use_s, is_sub;
   logic signed [WORD_W-1:0] addend, mx, my;
   logic signed [WORD_W:0]   sum;
   logic [WORD_W:0]          add_sat;
   logic [WORD_W-1:0]        num_mag, den_mag;

   logic signed [63:0]       p0_ff, p1_ff;
   logic [WORD_W:0]          add_ff;
   logic [WORD_W-1:0]        num1_ff, den1_ff;
   logic                     neg1_ff, numneg1_ff, dz1_ff;

   logic signed [63:0]       pm;
   logic signed [64:0]       dif, dsh;
   logic [WORD_W:0]          mul_sat, crs_sat, sel;
   lane_side_type            lane_ff;

   // stage 1: operands and products
   always_comb begin
      is_cross = (op_in == OP_CROSS);
      is_sq    = (op_in == OP_MAGSQ) || (op_in == OP_MAG) || (op_in == OP_NORM);
      use_s    = (op_in == OP_ADDS) || (op_in == OP_SUBS) || (op_in == OP_MULS) ||
                 (op_in == OP_DIVS);
      is_sub   = (op_in == OP_SUBV) || (op_in == OP_SUBS);
      addend   = use_s ? s : b_own;
      mx       = is_cross ? cx_a0 : a_own;
      my       = is_cross ? cx_b0 : (is_sq ? a_own : addend);
      sum      = is_sub ? ({a_own[WORD_W-1], a_own} - {addend[WORD_W-1], addend})
                        : ({a_own[WORD_W-1], a_own} + {addend[WORD_W-1], addend});
      add_sat  = sat_word({{(SAT_W-WORD_W-1){sum[WORD_W]}}, sum});
      num_mag  = a_own[WORD_W-1] ? (~a_own + 32'd1) : a_own;
      den_mag  = addend[WORD_W-1] ? (~addend + 32'd1) : addend;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff      <= 64'(mx) * 64'(my);
         p1_ff      <= 64'(cx_a1) * 64'(cx_b1);
         add_ff     <= add_sat;
         num1_ff    <= num_mag;
         den1_ff    <= den_mag;
         neg1_ff    <= (op_in == OP_NORM) ? a_own[WORD_W-1]
                                          : (a_own[WORD_W-1] ^ addend[WORD_W-1]);
         numneg1_ff <= a_own[WORD_W-1];
         dz1_ff     <= (addend == '0);
      end
   end

   // stage 2: floor shift and clamp
   always_comb begin
      pm      = p0_ff >>> FRAC_BITS;
      mul_sat = sat_word({{(SAT_W-64){pm[63]}}, pm});
      dif     = {p0_ff[63], p0_ff} - {p1_ff[63], p1_ff};
      dsh     = dif >>> FRAC_BITS;
      crs_sat = sat_word({{(SAT_W-65){dsh[64]}}, dsh});
      case (op_s1)
         OP_ADDV, OP_ADDS, OP_SUBV, OP_SUBS: sel = add_ff;
         OP_MULV, OP_MULS:                   sel = mul_sat;
         OP_CROSS:                           sel = crs_sat;
         default:                            sel = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff.res      <= sel[WORD_W-1:0];
         lane_ff.ov       <= sel[WORD_W];
         lane_ff.num      <= num1_ff;
         lane_ff.den      <= den1_ff;
         lane_ff.neg      <= neg1_ff;
         lane_ff.num_neg  <= numneg1_ff;
         lane_ff.den_zero <= dz1_ff;
      end
   end

   assign prod   = p0_ff;
   assign lane_o = lane_ff;

endmodule
`default_nettype wire

>>> rtl/vau_merge.sv
// Merge stage: dot product and sum of squares across the three lanes.
`timescale 1ns / 1ps
`default_nettype none
module vau_merge #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                en,
   input  vau_pkg::opcode_type op_s1,
   input  logic signed [63:0]  p0,
   input  logic signed [63:0]  p1,
   input  logic signed [63:0]  p2,
   output logic signed [31:0]  rs,
   output logic                rs_ov,
   output logic [63:0]         sq
);
   import vau_pkg::*;

   logic signed [SAT_W-1:0] dot, dsh;
   logic [WORD_W:0]         dsat, sel;
   logic [63:0]             sq_sum, msq;
   logic signed [WORD_W-1:0] rs_ff;
   logic                    rs_ov_ff;
   logic [63:0]             sq_ff;

   always_comb begin
      dot    = {{(SAT_W-64){p0[63]}}, p0} + {{(SAT_W-64){p1[63]}}, p1} +
               {{(SAT_W-64){p2[63]}}, p2};
      dsh    = dot >>> FRAC_BITS;
      dsat   = sat_word(dsh);
      sq_sum = p0 + p1 + p2;   // squares: each non-negative, sum fits
      msq    = sq_sum >> FRAC_BITS;
      case (op_s1)
         OP_DOT:   sel = dsat;
         OP_MAGSQ: sel = (|msq[63:WORD_W-1]) ? {1'b1, WORD_MAX} : {1'b0, msq[WORD_W-1:0]};
         default:  sel = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rs_ff    <= sel[WORD_W-1:0];
         rs_ov_ff <= sel[WORD_W];
         sq_ff    <= sq_sum;
      end
   end

   assign rs    = rs_ff;
   assign rs_ov = rs_ov_ff;
   assign sq    = sq_ff;

endmodule
`default_nettype wire

>>> rtl/vau_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module vau_sqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] rad,
   output logic [31:0] root
);
   import vau_pkg::*;

   logic [31:0] rem_ff  [SQRT_STAGES-1];
   logic [63:0] rad_ff  [SQRT_STAGES-1];
   logic [31:0] root_ff [SQRT_STAGES];
   logic [31:0] rem_in  [SQRT_STAGES-1];
   logic [31:0] root_in [SQRT_STAGES];

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      logic [31:0] rem_i, root_i;
      logic [63:0] rad_i;
      logic [33:0] sh, trial, diff;
      logic        ge;
      if (k == 0) begin : g_first
         assign rem_i  = '0;
         assign root_i = '0;
         assign rad_i  = rad;
      end else begin : g_next
         assign rem_i  = rem_ff[k-1];
         assign root_i = root_ff[k-1];
         assign rad_i  = rad_ff[k-1];
      end
      assign sh         = {rem_i, rad_i[2*(SQRT_STAGES-1-k)+1 -: 2]};
      assign trial      = {root_i, 2'b01};
      assign ge         = (sh >= trial);
      assign diff       = ge ? (sh - trial) : sh;
      assign root_in[k] = {root_i[30:0], ge};
      if (k < SQRT_STAGES-1) begin : g_carry
         assign rem_in[k] = diff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < SQRT_STAGES; k++) begin
            root_ff[k] <= root_in[k];
         end
         for (int k = 0; k < SQRT_STAGES-1; k++) begin
            rem_ff[k] <= rem_in[k];
         end
         rad_ff[0] <= rad;
         for (int k = 1; k < SQRT_STAGES-1; k++) begin
            rad_ff[k] <= rad_ff[k-1];
         end
      end
   end

   assign root = root_ff[SQRT_STAGES-1];

endmodule
`default_nettype wire

>>> rtl/vau_div.sv
// Pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module vau_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic [31:0]               num,
   input  logic [31:0]               den,
   output logic [32+FRAC_BITS-1:0]   quo
);
   import vau_pkg::*;

   localparam int QW = WORD_W + FRAC_BITS;

   logic [31:0]   rem_ff [QW-1];
   logic [31:0]   num_ff [QW-1];
   logic [31:0]   den_ff [QW-1];
   logic [QW-1:0] q_ff   [QW];
   logic [31:0]   rem_in [QW-1];
   logic [QW-1:0] q_in   [QW];

   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic [31:0]   rem_i, num_i, den_i;
      logic [QW-1:0] q_i;
      logic          nbit, ge;
      logic [32:0]   sh, diff;
      if (i == 0) begin : g_first
         assign rem_i = '0;
         assign num_i = num;
         assign den_i = den;
         assign q_i   = '0;
      end else begin : g_next
         assign rem_i = rem_ff[i-1];
         assign num_i = num_ff[i-1];
         assign den_i = den_ff[i-1];
         assign q_i   = q_ff[i-1];
      end
      if (QW-1-i >= FRAC_BITS) begin : g_num_bit
         assign nbit = num_i[QW-1-i-FRAC_BITS];
      end else begin : g_zero_bit
         assign nbit = 1'b0;
      end
      assign sh      = {rem_i, nbit};
      assign ge      = (sh >= {1'b0, den_i});
      assign diff    = ge ? (sh - {1'b0, den_i}) : sh;
      assign q_in[i] = {q_i[QW-2:0], ge};
      if (i < QW-1) begin : g_carry
         assign rem_in[i] = diff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < QW; i++) begin
            q_ff[i] <= q_in[i];
         end
         for (int i = 0; i < QW-1; i++) begin
            rem_ff[i] <= rem_in[i];
         end
         num_ff[0] <= num;
         den_ff[0] <= den;
         for (int i = 1; i < QW-1; i++) begin
            num_ff[i] <= num_ff[i-1];
            den_ff[i] <= den_ff[i-1];
         end
      end
   end

   assign quo = q_ff[QW-1];

endmodule
`default_nettype wire

>>> rtl/vector3_arithmetic_unit.sv
// Top level of the three-component Q16.16 vector arithmetic unit.
// Pipeline: 2 + 32 + (32 + FRAC_BITS) stages plus the output register, for every opcode.
// Throughput: one beat per cycle while rsp_stall does not hold the pipe; the 32-stage root
//   and (32 + FRAC_BITS)-stage divider are fully pipelined, so rate is set by nothing but the handshake.
// rsp_stall freezes the pipe only when its last stage holds a beat; bubbles drain.
// Reset (synchronous, active high) clears the valid bits; datapath registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module vector3_arithmetic_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  vau_pkg::opcode_type req_opcode,
   input  logic signed [31:0]  req_a_x,
   input  logic signed [31:0]  req_a_y,
   input  logic signed [31:0]  req_a_z,
   input  logic signed [31:0]  req_b_x,
   input  logic signed [31:0]  req_b_y,
   input  logic signed [31:0]  req_b_z,
   input  logic signed [31:0]  req_scalar_b,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_r_x,
   output logic signed [31:0]  rsp_r_y,
   output logic signed [31:0]  rsp_r_z,
   output logic signed [31:0]  rsp_r_scalar,
   output logic                rsp_overflow,
   output logic                rsp_div_zero
);
   import vau_pkg::*;

   localparam int QW         = WORD_W + FRAC_BITS;   // quotient width
   localparam int DIV_STAGES = QW;
   localparam int NST        = 2 + SQRT_STAGES + DIV_STAGES;

   // pipeline control: a beat moves whenever the last stage can drain
   logic           adv;
   logic [NST-1:0] vld_ff;
   logic           rsp_valid_ff;

   assign adv       = !(vld_ff[NST-1] && rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], req_valid};
      end
   end

   // operand vectors for the lanes
   logic signed [WORD_W-1:0] a_vec [3];
   logic signed [WORD_W-1:0] b_vec [3];
   assign a_vec[0] = req_a_x;
   assign a_vec[1] = req_a_y;
   assign a_vec[2] = req_a_z;
   assign b_vec[0] = req_b_x;
   assign b_vec[1] = req_b_y;
   assign b_vec[2] = req_b_z;

   opcode_type op_s1_ff, op_s2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         op_s1_ff <= req_opcode;
         op_s2_ff <= op_s1_ff;
      end
   end

   // three lanes, one per component; lane i also forms its cross term
   logic signed [63:0] prod [3];
   lane_side_type      lane_o [3];

   for (genvar i = 0; i < 3; i++) begin : g_lane
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;
      vau_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock  (clock),
         .en     (adv),
         .op_in  (req_opcode),
         .op_s1  (op_s1_ff),
         .a_own  (a_vec[i]),
         .b_own  (b_vec[i]),
         .s      (req_scalar_b),
         .cx_a0  (a_vec[J]),
         .cx_b0  (b_vec[K]),
         .cx_a1  (a_vec[K]),
         .cx_b1  (b_vec[J]),
         .prod   (prod[i]),
         .lane_o (lane_o[i])
      );
   end

   // merge: dot product, squared magnitude, sum of squares
   logic signed [WORD_W-1:0] mrg_rs;
   logic                     mrg_rs_ov;
   logic [63:0]              mrg_sq;

   vau_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
      .clock (clock),
      .en    (adv),
      .op_s1 (op_s1_ff),
      .p0    (prod[0]),
      .p1    (prod[1]),
      .p2    (prod[2]),
      .rs    (mrg_rs),
      .rs_ov (mrg_rs_ov),
      .sq    (mrg_sq)
   );

   side_type side_s2;
   always_comb begin
      side_s2.op       = op_s2_ff;
      side_s2.lanes[0] = lane_o[0];
      side_s2.lanes[1] = lane_o[1];
      side_s2.lanes[2] = lane_o[2];
      side_s2.rs       = mrg_rs;
      side_s2.rs_ov    = mrg_rs_ov;
      side_s2.sq_zero  = (mrg_sq == '0);
   end

   // root of the sum of squares, side data rides alongside
   logic [31:0] root;
   vau_sqrt u_sqrt (
      .clock (clock),
      .en    (adv),
      .rad   (mrg_sq),
      .root  (root)
   );

   side_type sq_line_ff [SQRT_STAGES];
   side_type dv_line_ff [DIV_STAGES];
   side_type side_mag, side_end;

   always_comb begin
      side_mag = sq_line_ff[SQRT_STAGES-1];
      if (side_mag.op == OP_MAG) begin
         side_mag.rs    = root[WORD_W-1] ? WORD_MAX : root;
         side_mag.rs_ov = root[WORD_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_line_ff[0] <= side_s2;
         for (int k = 1; k < SQRT_STAGES; k++) begin
            sq_line_ff[k] <= sq_line_ff[k-1];
         end
         dv_line_ff[0] <= side_mag;
         for (int k = 1; k < DIV_STAGES; k++) begin
            dv_line_ff[k] <= dv_line_ff[k-1];
         end
      end
   end

   assign side_end = dv_line_ff[DIV_STAGES-1];

   // one divider per lane; normalize divides by the root
   logic [QW-1:0]      quo  [3];
   logic [WORD_W:0]    qsat [3];

   for (genvar i = 0; i < 3; i++) begin : g_div
      logic [WORD_W-1:0]       den_sel;
      logic signed [SAT_W-1:0] qmag;
      assign den_sel = (side_mag.op == OP_NORM) ? root : side_mag.lanes[i].den;
      vau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock (clock),
         .en    (adv),
         .num   (side_mag.lanes[i].num),
         .den   (den_sel),
         .quo   (quo[i])
      );
      assign qmag    = {{(SAT_W-QW){1'b0}}, quo[i]};
      assign qsat[i] = sat_word(side_end.lanes[i].neg ? -qmag : qmag);
   end

   // final select
   logic [WORD_W-1:0] fin_r [3];
   logic              fin_ov, fin_dz;

   always_comb begin
      fin_ov = side_end.rs_ov;
      fin_dz = 1'b0;
      for (int i = 0; i < 3; i++) begin
         case (side_end.op)
            OP_DIVV, OP_DIVS: begin
               if (side_end.lanes[i].den_zero) begin
                  fin_r[i] = side_end.lanes[i].num_neg ? WORD_MIN : WORD_MAX;
                  fin_dz   = 1'b1;
               end else begin
                  fin_r[i] = qsat[i][WORD_W-1:0];
                  fin_ov   = fin_ov | qsat[i][WORD_W];
               end
            end
            OP_NORM: begin
               // zero vector normalizes to zero
               if (side_end.sq_zero) begin
                  fin_r[i] = '0;
               end else begin
                  fin_r[i] = qsat[i][WORD_W-1:0];
                  fin_ov   = fin_ov | qsat[i][WORD_W];
               end
            end
            default: begin
               fin_r[i] = side_end.lanes[i].res;
               fin_ov   = fin_ov | side_end.lanes[i].ov;
            end
         endcase
      end
   end

   // output register: refills whenever empty or being taken
   logic [WORD_W-1:0] rsp_r_x_ff, rsp_r_y_ff, rsp_r_z_ff, rsp_r_scalar_ff;
   logic              rsp_overflow_ff, rsp_div_zero_ff;
   opcode_type        rsp_op_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= vld_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_r_x_ff      <= fin_r[0];
         rsp_r_y_ff      <= fin_r[1];
         rsp_r_z_ff      <= fin_r[2];
         rsp_r_scalar_ff <= side_end.rs;
         rsp_overflow_ff <= fin_ov;
         rsp_div_zero_ff <= fin_dz;
         rsp_op_ff       <= side_end.op;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_r_x      = rsp_r_x_ff;
   assign rsp_r_y      = rsp_r_y_ff;
   assign rsp_r_z      = rsp_r_z_ff;
   assign rsp_r_scalar = rsp_r_scalar_ff;
   assign rsp_overflow = rsp_overflow_ff;
   assign rsp_div_zero = rsp_div_zero_ff;

   // a held result with a beat behind it must back-pressure the input
   a_hold_stalls_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && vld_ff[NST-1]) |-> req_stall)
      else $error("pipe advanced over a held result");

   // divide-by-zero flag only from divide opcodes
   a_dz_only_div: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_zero) |-> (rsp_op_ff == OP_DIVV || rsp_op_ff == OP_DIVS))
      else $error("div_zero raised by non-divide op");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // a stalled last stage keeps its beat
   a_last_kept: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NST-1] && !adv) |=> vld_ff[NST-1])
      else $error("beat lost in last stage");

endmodule
`default_nettype wire

>>> tb/tb_vector3_arithmetic_unit.sv
// Self-checking testbench for the Q16.16 three-component vector arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
module tb_vector3_arithmetic_unit;
   import vau_pkg::*;

   localparam int FRAC      = 16;
   localparam int LATENCY   = 82;        // pipeline depth in stages, used for the final drain wait
   localparam int MAX_CYCLE = 600000;    // far beyond the slowest legal run
   localparam int N_RANDOM  = 1125;

   // one result beat as the block should present it
   typedef struct {
      logic signed [31:0] r_x, r_y, r_z, r_scalar;
      logic               overflow, div_zero;
   } vec_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   opcode_type         req_opcode = OP_ADDV;
   logic signed [31:0] req_a_x = '0, req_a_y = '0, req_a_z = '0;
   logic signed [31:0] req_b_x = '0, req_b_y = '0, req_b_z = '0;
   logic signed [31:0] req_scalar_b = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_r_x, rsp_r_y, rsp_r_z, rsp_r_scalar;
   logic               rsp_overflow, rsp_div_zero;

   vec_result_type pending_results[$];
   int             mismatches = 0;
   int             cycles = 0;
   int             stall_mode = 0;

   vector3_arithmetic_unit #(.FRAC_BITS(FRAC)) u_top (.*);

   always #6 clock = ~clock;

   // ---------------------------------------------------------------- predictor
   // Saturate a wide signed value into a 32-bit word, flagging overflow.
   function automatic logic signed [31:0] clamp_word(input logic signed [127:0] v,
                                                     inout bit ov);
      if (v > 128'sd2147483647) begin
         ov = 1'b1;
         return 32'sh7FFF_FFFF;
      end
      if (v < -128'sd2147483648) begin
         ov = 1'b1;
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // Fixed-point quotient, truncated toward zero; zero divisor saturates by dividend sign.
   function automatic logic signed [31:0] quotient(input longint num, input longint den,
                                                   inout bit ov, inout bit dz);
      logic [63:0] un, ud, uq;
      logic signed [127:0] sq;
      if (den == 0) begin
         dz = 1'b1;
         return (num >= 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      end
      un = (num < 0) ? -num : num;
      ud = (den < 0) ? -den : den;
      uq = (un << FRAC) / ud;
      if (uq > (64'd1 << 40)) uq = 64'd1 << 40;
      sq = $signed({64'd0, uq});
      if ((num < 0) != (den < 0)) sq = -sq;
      return clamp_word(sq, ov);
   endfunction

   // Floor of the square root of a value below 2^64.
   function automatic logic [63:0] floor_root(input logic [63:0] n);
      logic [127:0] trial;
      logic [63:0]  root;
      root = '0;
      for (int i = 32; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= {64'd0, n}) root = trial[63:0];
      end
      return root;
   endfunction

   function automatic vec_result_type vector_math(input opcode_type op,
         input logic signed [31:0] ax, ay, az, bx, by, bz, sb);
      vec_result_type      res;
      longint              a[3], b[3], s;
      logic signed [127:0] wide;
      logic [63:0]         mag_sq, root, ua;
      bit                  ov, dz;
      ov = 0; dz = 0;
      res = '{default: '0};
      a[0] = ax; a[1] = ay; a[2] = az;
      b[0] = bx; b[1] = by; b[2] = bz;
      s = sb;
      mag_sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
      case (op)
         OP_ADDV, OP_ADDS, OP_SUBV, OP_SUBS, OP_MULV, OP_MULS, OP_DIVV, OP_DIVS: begin
            for (int i = 0; i < 3; i++) begin
               logic signed [31:0] c;
               longint rhs;
               rhs = (op == OP_ADDV || op == OP_SUBV || op == OP_MULV || op == OP_DIVV)
                     ? b[i] : s;
               case (op)
                  OP_ADDV, OP_ADDS: c = clamp_word(128'(a[i]) + 128'(rhs), ov);
                  OP_SUBV, OP_SUBS: c = clamp_word(128'(a[i]) - 128'(rhs), ov);
                  OP_MULV, OP_MULS: c = clamp_word((128'(a[i]) * 128'(rhs)) >>> FRAC, ov);
                  default:          c = quotient(a[i], rhs, ov, dz);
               endcase
               if (i == 0) res.r_x = c;
               else if (i == 1) res.r_y = c;
               else res.r_z = c;
            end
         end
         OP_DOT: begin
            wide = 128'(a[0]) * 128'(b[0]) + 128'(a[1]) * 128'(b[1])
                 + 128'(a[2]) * 128'(b[2]);
            res.r_scalar = clamp_word(wide >>> FRAC, ov);
         end
         OP_CROSS: begin
            res.r_x = clamp_word((128'(a[1]) * 128'(b[2]) - 128'(a[2]) * 128'(b[1]))
                                 >>> FRAC, ov);
            res.r_y = clamp_word((128'(a[2]) * 128'(b[0]) - 128'(a[0]) * 128'(b[2]))
                                 >>> FRAC, ov);
            res.r_z = clamp_word((128'(a[0]) * 128'(b[1]) - 128'(a[1]) * 128'(b[0]))
                                 >>> FRAC, ov);
         end
         OP_MAGSQ: res.r_scalar = clamp_word($signed({64'd0, mag_sq >> FRAC}), ov);
         OP_MAG:   res.r_scalar = clamp_word($signed({64'd0, floor_root(mag_sq)}), ov);
         OP_NORM: begin
            if (mag_sq != 0) begin
               root = floor_root(mag_sq);
               for (int i = 0; i < 3; i++) begin
                  logic signed [31:0] c;
                  ua = (a[i] < 0) ? -a[i] : a[i];
                  wide = $signed({64'd0, (ua << FRAC) / root});
                  c = clamp_word((a[i] < 0) ? -wide : wide, ov);
                  if (i == 0) res.r_x = c;
                  else if (i == 1) res.r_y = c;
                  else res.r_z = c;
               end
            end
         end
         default: ;   // unused opcodes give all zeros
      endcase
      res.overflow = ov;
      res.div_zero = dz;
      return res;
   endfunction

   // ---------------------------------------------------------------- driving
   // Present one beat and hold it until accepted; the expectation is queued on acceptance.
   task automatic send_beat(input opcode_type op,
         input logic signed [31:0] ax, ay, az, bx, by, bz, sb);
      @(negedge clock);
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_a_x <= ax; req_a_y <= ay; req_a_z <= az;
      req_b_x <= bx; req_b_y <= by; req_b_z <= bz;
      req_scalar_b <= sb;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(vector_math(op, ax, ay, az, bx, by, bz, sb));
   endtask

   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Half mid-range Q16.16 values, the rest extremes, zero and raw random bits.
   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(0, 11))
         0:       return 32'sh0;
         1:       return 32'sh7FFF_FFFF;
         2:       return 32'sh8000_0000;
         3, 4, 5: return $urandom;
         6:       return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
         default: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      endcase
   endfunction

   // receiver stall pattern: a random mode is picked periodically, mode 0 never stalls
   always @(negedge clock) begin
      if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 9) < 3);
         2:       rsp_stall <= ($urandom_range(0, 9) < 8);
         default: rsp_stall <= (cycles % 7 < 2);
      endcase
   end

   // ---------------------------------------------------------------- checking
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat at cycle %0d", cycles);
         end else begin
            vec_result_type want;
            want = pending_results.pop_front();
            if (rsp_r_x !== want.r_x || rsp_r_y !== want.r_y || rsp_r_z !== want.r_z ||
                rsp_r_scalar !== want.r_scalar || rsp_overflow !== want.overflow ||
                rsp_div_zero !== want.div_zero) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch cycle %0d: exp %h %h %h s=%h ov=%b dz=%b",
                            " got %h %h %h s=%h ov=%b dz=%b"},
                           cycles, want.r_x, want.r_y, want.r_z, want.r_scalar,
                           want.overflow, want.div_zero, rsp_r_x, rsp_r_y, rsp_r_z,
                           rsp_r_scalar, rsp_overflow, rsp_div_zero);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLE) begin
         $display("[vector3_arithmetic_unit] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests
   localparam logic signed [31:0] P_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] N_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] ONE   = 32'sh0001_0000;

   task automatic test_directed();
      // every defined opcode on plain values
      for (int op = 0; op <= 12; op++)
         send_beat(opcode_type'(op), 3 * ONE, -2 * ONE, ONE / 2, ONE, 4 * ONE, -ONE, 2 * ONE);
      send_beat(OP_ADDV, P_MAX, N_MIN, P_MAX, ONE, -ONE, P_MAX, 0);      // add saturation
      send_beat(OP_SUBS, N_MIN, P_MAX, 0, 0, 0, 0, ONE);                 // sub saturation
      send_beat(OP_MULV, N_MIN, N_MIN, P_MAX, N_MIN, P_MAX, -1, 0);      // product extremes
      send_beat(OP_DIVV, ONE, 0, -ONE, 0, 0, 0, 0);                      // divide by zero, all signs
      send_beat(OP_DIVS, N_MIN, P_MAX, 1, 0, 0, 0, 1);                   // quotient overflow
      send_beat(OP_DOT, N_MIN, N_MIN, N_MIN, N_MIN, N_MIN, N_MIN, 0);
      send_beat(OP_CROSS, N_MIN, P_MAX, N_MIN, P_MAX, N_MIN, P_MAX, 0);
      send_beat(OP_MAGSQ, N_MIN, N_MIN, N_MIN, 0, 0, 0, 0);              // magsq overflow
      send_beat(OP_MAG, N_MIN, N_MIN, N_MIN, 0, 0, 0, 0);                // mag overflow
      send_beat(OP_NORM, 0, 0, 0, ONE, ONE, ONE, ONE);                   // zero vector
      send_beat(OP_NORM, 1, 0, 0, 0, 0, 0, 0);                           // tiny vector normalizes to one
      for (int op = 13; op <= 15; op++)                                   // unused opcodes
         send_beat(opcode_type'(op), P_MAX, N_MIN, -1, -1, P_MAX, N_MIN, -1);
      idle_cycles(1);
   endtask

   // Bursts of random beats separated by random gaps, some bursts back to back.
   task automatic test_random(input int count);
      int sent;
      logic signed [31:0] bx, by, bz, sb;
      sent = 0;
      while (sent < count) begin
         repeat ($urandom_range(1, 40)) begin
            if (sent < count) begin
               bx = pick_word(); by = pick_word(); bz = pick_word(); sb = pick_word();
               if ($urandom_range(0, 9) == 0) sb = 0;           // extra zero divisors
               send_beat(opcode_type'($urandom_range(0, 15)), pick_word(), pick_word(),
                         pick_word(), bx, by, bz, sb);
               sent++;
            end
         end
         if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
      end
      idle_cycles(1);
   endtask

   // Sender holds off until the pipe has fully drained, then restarts.
   task automatic test_drain_pause();
      while (pending_results.size() != 0) @(negedge clock);
      send_beat(OP_DIVS, ONE, -ONE, 0, 0, 0, 0, 0);
      send_beat(OP_MAG, ONE, ONE, ONE, 0, 0, 0, 0);
      idle_cycles(1);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(N_RANDOM / 2);
      test_drain_pause();
      test_random(N_RANDOM - N_RANDOM / 2);
      while (pending_results.size() != 0) @(negedge clock);
      repeat (LATENCY + 20) @(negedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("[vector3_arithmetic_unit] OK");
      end else begin
         $display("[vector3_arithmetic_unit] ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
